[rtl/chte_pkg.sv]
package chte_pkg;

  localparam int unsigned NumBuckets  = 256;
  localparam int unsigned PoolEntries = 1024;
  localparam int unsigned BktW  = $clog2(NumBuckets);
  localparam int unsigned NodeW = $clog2(PoolEntries);
  localparam int unsigned LinkW = NodeW + 1;
  localparam int unsigned CntW  = 11;
  localparam int unsigned CfgW  = 9;
  localparam int unsigned QDepth = 2;

  localparam logic [LinkW-1:0] NullLink = LinkW'(PoolEntries);

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    ReqInsert = 2'd0,
    ReqLookup = 2'd1,
    ReqRemove = 2'd2,
    ReqNone   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StNull     = 2'd3
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]      req_type;
    logic [63:0]     key;
    logic [63:0]     value;
    logic [BktW-1:0] bucket;
  } job_t;

  // fnv prime is 2^40 + 0x1b3: multiply by shift and small product
  function automatic logic [63:0] fnv_mul(input logic [63:0] h);
    fnv_mul = (h << 40) + (h * 64'h1b3);
  endfunction

endpackage

[rtl/chte_front.sv]
module chte_front import chte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] buckets_in_use_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [63:0]     key_i,
  input  logic [63:0]     value_in_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output job_t            job_o
);

  localparam logic [2:0] FIdle = 3'd0;
  localparam logic [2:0] FHash = 3'd1;
  localparam logic [2:0] FMod  = 3'd2;
  localparam logic [2:0] FOut  = 3'd3;

  logic [2:0]       state_q, state_d;
  logic [2:0]       byte_q, byte_d;
  logic [63:0]      h_q, h_d;
  logic [63:0]      key_q, key_d;
  logic [63:0]      val_q, val_d;
  logic [1:0]       kind_q, kind_d;
  logic [72:0]      rem_q, rem_d;
  logic [6:0]       mstep_q, mstep_d;
  logic [CfgW-1:0]  mod_q, mod_d;
  logic [CfgW-1:0]  mod_eff;
  logic [7:0]       cur_byte;
  logic [CfgW:0]    trial;

  assign in_stall_o  = (state_q != FIdle);
  assign job_valid_o = (state_q == FOut);
  assign job_o = '{req_type: kind_q, key: key_q, value: val_q,
                   bucket: BktW'(rem_q[72:64])};

  // clamp bucket count into 1..NumBuckets
  always_comb begin
    mod_eff = buckets_in_use_i;
    if (buckets_in_use_i == '0) mod_eff = CfgW'(1);
    else if (buckets_in_use_i > CfgW'(NumBuckets)) mod_eff = CfgW'(NumBuckets);
  end

  assign cur_byte = key_q[8*byte_q +: 8];
  // restoring division step: shift in next dividend bit
  assign trial = {rem_q[72:64], rem_q[63]} - {1'b0, mod_q};

  always_comb begin
    state_d = state_q; byte_d = byte_q; h_d = h_q; key_d = key_q;
    val_d = val_q; kind_d = kind_q; rem_d = rem_q; mstep_d = mstep_q;
    mod_d = mod_q;
    unique case (state_q)
      FIdle: begin
        if (in_valid_i) begin
          key_d = key_i; val_d = value_in_i; kind_d = req_type_i;
          h_d = FnvBasis; byte_d = '0; mod_d = mod_eff;
          state_d = FHash;
        end
      end
      // one byte of fnv-1a per cycle
      FHash: begin
        h_d = fnv_mul(h_q ^ {56'd0, cur_byte});
        byte_d = byte_q + 3'd1;
        if (byte_q == 3'd7) begin
          state_d = FMod; mstep_d = '0;
        end
      end
      FMod: begin
        if (mstep_q == 7'd0) begin
          rem_d = {9'd0, h_q};
          mstep_d = 7'd1;
        end else begin
          if (!trial[CfgW]) rem_d = {trial[CfgW-1:0], rem_q[62:0], 1'b1};
          else rem_d = {rem_q[71:0], 1'b0};
          mstep_d = mstep_q + 7'd1;
          if (mstep_q == 7'd64) state_d = FOut;
        end
      end
      FOut: begin
        if (job_ready_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FIdle;
      mstep_q <= '0;
      byte_q  <= '0;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      byte_q  <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; key_q <= key_d; val_q <= val_d; kind_q <= kind_d;
    rem_q <= rem_d; mod_q <= mod_d;
  end

endmodule

[rtl/chte_queue.sv]
module chte_queue import chte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic ready_o,
  input  job_t push_data_i,
  output logic valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign ready_o    = (cnt_q != (PtrW+1)'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  // pointer and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && ready_o) wr_q <= wr_q + 1'b1;
      if (pop_i && valid_o)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i && ready_o) - (PtrW+1)'(pop_i && valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) mem_q[wr_q] <= push_data_i;
  end

endmodule

[rtl/chte_back.sv]
module chte_back import chte_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_pop_o,
  input  job_t           job_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic           found_o,
  output logic [63:0]    value_out_o,
  output logic [CntW-1:0] entry_count_o
);

  localparam logic [3:0] BIdle  = 4'd0;
  localparam logic [3:0] BClear = 4'd1;
  localparam logic [3:0] BHead  = 4'd2;
  localparam logic [3:0] BHeadW = 4'd3;
  localparam logic [3:0] BNode  = 4'd4;
  localparam logic [3:0] BNodeW = 4'd5;
  localparam logic [3:0] BCheck = 4'd6;
  localparam logic [3:0] BAlloc = 4'd7;
  localparam logic [3:0] BFreeW = 4'd8;
  localparam logic [3:0] BRes   = 4'd9;

  // memories
  logic [LinkW-1:0] head_mem [NumBuckets];
  logic [63:0]      key_mem  [PoolEntries];
  logic [63:0]      val_mem  [PoolEntries];
  logic [LinkW-1:0] link_mem [PoolEntries];

  logic [3:0]       state_q, state_d;
  job_t             job_q;
  logic [BktW:0]    clr_q;
  logic [LinkW-1:0] head_rd_q, link_rd_q;
  logic [63:0]      key_rd_q, val_rd_q;
  logic [LinkW-1:0] cur_q, prev_q, free_q, fresh_q;
  logic [CntW-1:0]  held_q;
  logic [NodeW-1:0] node_addr;
  logic [LinkW-1:0] steps_q;
  logic [1:0]       st_q;
  logic             fnd_q;
  logic [63:0]      vo_q;

  // head writes
  logic             hw_en;
  logic [BktW-1:0]  hw_addr;
  logic [LinkW-1:0] hw_data;
  // node link writes
  logic             lw_en;
  logic [NodeW-1:0] lw_addr;
  logic [LinkW-1:0] lw_data;
  logic             kv_en;

  assign job_pop_o     = (state_q == BIdle) && job_valid_i && !out_valid_o;
  assign out_valid_o   = (state_q == BRes);
  assign status_o      = st_q;
  assign found_o       = fnd_q;
  assign value_out_o   = vo_q;
  assign entry_count_o = held_q;
  assign node_addr     = cur_q[NodeW-1:0];

  always_comb begin
    state_d = state_q;
    hw_en = 1'b0; hw_addr = job_q.bucket; hw_data = cur_q;
    lw_en = 1'b0; lw_addr = cur_q[NodeW-1:0]; lw_data = free_q;
    kv_en = 1'b0;
    unique case (state_q)
      BClear: begin
        hw_en = 1'b1; hw_addr = clr_q[BktW-1:0]; hw_data = NullLink;
        if (clr_q == (BktW+1)'(NumBuckets - 1)) state_d = BIdle;
      end
      BIdle:  if (job_pop_o) state_d = BHead;
      BHead:  state_d = BHeadW;
      BHeadW: begin
        unique case (job_q.req_type)
          ReqInsert: state_d = (job_q.value == '0) ? BRes : BAlloc;
          ReqLookup, ReqRemove: state_d = BCheck;
          default: state_d = BRes;
        endcase
      end
      // node read at cur issued, data next cycle
      BNode:  state_d = BNodeW;
      BNodeW: state_d = BCheck;
      BCheck: begin
        if (cur_q == NullLink || steps_q == NullLink) state_d = BRes;
        else if (state_q == BCheck && key_rd_q == job_q.key && steps_q != '0)
          state_d = BRes;
        else state_d = BNode;
        if (cur_q != NullLink && steps_q != '0 && key_rd_q == job_q.key &&
            job_q.req_type == ReqRemove) begin
          if (prev_q != NullLink) begin
            lw_en = 1'b1; lw_addr = prev_q[NodeW-1:0]; lw_data = link_rd_q;
          end else begin
            hw_en = 1'b1; hw_data = link_rd_q;
          end
          state_d = BFreeW;
        end
      end
      BFreeW: begin
        lw_en = 1'b1; lw_addr = cur_q[NodeW-1:0]; lw_data = free_q;
        state_d = BRes;
      end
      BAlloc: begin
        // node link of the free head was read into link_rd_q in prior cycle
        if (cur_q != NullLink) begin
          kv_en = 1'b1; lw_en = 1'b1; lw_data = head_rd_q;
          hw_en = 1'b1; hw_data = cur_q;
        end
        state_d = BRes;
      end
      BRes: if (!out_stall_i) state_d = BIdle;
      default: state_d = BIdle;
    endcase
  end

  // control and bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BClear; clr_q <= '0;
      free_q <= NullLink; fresh_q <= '0; held_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BClear) clr_q <= clr_q + 1'b1;
      if (state_q == BAlloc && cur_q != NullLink) begin
        held_q <= held_q + 1'b1;
        if (free_q != NullLink) free_q <= link_rd_q;
        else fresh_q <= fresh_q + 1'b1;
      end
      if (state_q == BFreeW) begin
        free_q <= cur_q;
        if (held_q != '0) held_q <= held_q - 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    unique case (state_q)
      BHead: begin
        prev_q <= NullLink; steps_q <= '0;
        // pick node for insert; its free head link is read from it in BHeadW
        cur_q <= (free_q != NullLink) ? free_q :
                 ((fresh_q < NullLink) ? fresh_q : NullLink);
      end
      BHeadW: begin
        if (job_q.req_type != ReqInsert) cur_q <= head_rd_q;
        st_q <= StOk; fnd_q <= 1'b0; vo_q <= '0;
        if (job_q.req_type == ReqInsert) begin
          if (job_q.value == '0) st_q <= StNull;
        end else if (job_q.req_type != ReqNone) st_q <= StNotFound;
      end
      BCheck: begin
        if (cur_q != NullLink && steps_q != '0 && steps_q != NullLink + 1'b1) begin
          if (key_rd_q == job_q.key) begin
            st_q <= StOk; fnd_q <= 1'b1;
            if (job_q.req_type == ReqLookup) vo_q <= val_rd_q;
          end else begin
            prev_q <= cur_q; cur_q <= link_rd_q;
          end
        end
        if (steps_q == '0 && cur_q != NullLink) steps_q <= steps_q;
      end
      BNodeW: steps_q <= steps_q + 1'b1;
      BAlloc: if (cur_q == NullLink) st_q <= StFull;
      default: ;
    endcase
  end

  // head table: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (hw_en) head_mem[hw_addr] <= hw_data;
    head_rd_q <= head_mem[job_q.bucket];
  end

  // node pool: one write port, registered read at cur
  always_ff @(posedge clk_i) begin
    if (kv_en) begin
      key_mem[node_addr] <= job_q.key;
      val_mem[node_addr] <= job_q.value;
    end
    if (lw_en) link_mem[lw_addr] <= lw_data;
    key_rd_q  <= key_mem[node_addr];
    val_rd_q  <= val_mem[node_addr];
    link_rd_q <= link_mem[node_addr];
  end

endmodule

[rtl/chained_hash_table_engine.sv]
// Chained hash table engine: 64-bit keys and values in a 1024-node pool over
// up to 256 buckets. A front end hashes each key (FNV-1a, one byte a cycle)
// and reduces it modulo the bucket count with a bit-serial divider; a
// two-entry queue feeds the back end, which walks the chain one node at a
// time (states BNode, BNodeW, BCheck) through the node memory with its one
// write port and registered read. After reset the back end clears all 256
// bucket heads before it starts work.
module chained_hash_table_engine import chte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  logic [63:0]     key_i,
  input  logic [63:0]     value_in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      status_o,
  output logic            found_o,
  output logic [63:0]     value_out_o,
  output logic [CntW-1:0] entry_count_o
);

  logic [CfgW-1:0] buckets_q;
  logic            f_valid, q_ready, q_valid, q_pop;
  job_t            f_job, q_job;

  // bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) buckets_q <= CfgW'(NumBuckets);
    else if (cfg_we_i) buckets_q <= cfg_wdata_i;
  end

  chte_front u_front (
    .clk_i, .rst_ni,
    .buckets_in_use_i(buckets_q),
    .in_valid_i, .in_stall_o, .req_type_i, .key_i, .value_in_i,
    .job_valid_o(f_valid), .job_ready_i(q_ready), .job_o(f_job)
  );

  chte_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(f_valid), .ready_o(q_ready), .push_data_i(f_job),
    .valid_o(q_valid), .pop_i(q_pop), .pop_data_o(q_job)
  );

  chte_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_pop_o(q_pop), .job_i(q_job),
    .out_valid_o, .out_stall_i, .status_o, .found_o, .value_out_o, .entry_count_o
  );

endmodule
